FILE: rtl/core/csps_pkg.sv
// Shared types, codes and constants of the clock servo.
`default_nettype none
package csps_pkg;

   localparam int FRAC_BITS = 16;
   localparam int OFFSET_W = 41;
   localparam int GAIN_W = 32;
   localparam int MAXOFF_W = 30;
   localparam int RATIO_W = 32;
   localparam int ACTION_W = 2;
   localparam int PHASE_W = 2;
   localparam int MUL_W = 31;
   localparam int SUM_W = 64;
   localparam int INTEG_W = 25;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam int ADJ_LIMIT = 10000000;
   localparam logic [OFFSET_W-1:0] ONE_SECOND_NS = OFFSET_W'(1000000000);
   localparam logic [MAXOFF_W-1:0] MAXOFF_RESET = MAXOFF_W'(1000000);

   localparam logic [ACTION_W-1:0] ACT_RATE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_STEP = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_SKIP = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_REJECT = 2'd3;

   localparam logic [PHASE_W-1:0] PHASE_NORMAL = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_PENDING = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_STEPPED = 2'd2;

   localparam logic [1:0] REG_PROP_GAIN = 2'd0;
   localparam logic [1:0] REG_INTEG_GAIN = 2'd1;
   localparam logic [1:0] REG_OFFSET_LIMIT = 2'd2;

   typedef logic signed [SUM_W-1:0] sum_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] prop_gain;
      logic signed [GAIN_W-1:0] integ_gain;
      logic [MAXOFF_W-1:0] offset_limit;
   } cfg_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic signed [INTEG_W-1:0] integ;
   } state_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic signed [RATIO_W-1:0] ratio_adjust;
      logic [OFFSET_W-1:0] step_ns;
      logic reset_pending;
   } result_type;

endpackage
`default_nettype wire

FILE: rtl/core/csps_regs.sv
// Configuration register bank behind the APB-style port.
`default_nettype none
module csps_regs (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_psel,
   input wire logic csr_penable,
   input wire logic csr_pwrite,
   input wire logic [csps_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input wire logic [csps_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [csps_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready,
   output csps_pkg::cfg_type cfg
);

   csps_pkg::cfg_type cfg_ff;
   csps_pkg::cfg_type cfg_in;
   logic [1:0] index;
   logic write_en;

   assign index = csr_paddr[3:2];
   assign write_en = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            csps_pkg::REG_PROP_GAIN: cfg_in.prop_gain = csr_pwdata;
            csps_pkg::REG_INTEG_GAIN: cfg_in.integ_gain = csr_pwdata;
            csps_pkg::REG_OFFSET_LIMIT:
               cfg_in.offset_limit = csr_pwdata[csps_pkg::MAXOFF_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         csps_pkg::REG_PROP_GAIN: csr_prdata = cfg_ff.prop_gain;
         csps_pkg::REG_INTEG_GAIN: csr_prdata = cfg_ff.integ_gain;
         csps_pkg::REG_OFFSET_LIMIT:
            csr_prdata = {{(csps_pkg::CSR_DATA_W - csps_pkg::MAXOFF_W){1'b0}},
                          cfg_ff.offset_limit};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain <= '0;
         cfg_ff.integ_gain <= '0;
         cfg_ff.offset_limit <= csps_pkg::MAXOFF_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/csps_pi.sv
// Servo decision and PI arithmetic for one offset, with the next servo state.
`default_nettype none
module csps_pi (
   input wire logic signed [csps_pkg::OFFSET_W-1:0] offset_ns,
   input wire csps_pkg::cfg_type cfg,
   input wire csps_pkg::state_type state,
   output csps_pkg::state_type state_next,
   output csps_pkg::result_type result
);

   localparam int F = csps_pkg::FRAC_BITS;
   localparam int PROD_W = csps_pkg::MUL_W + csps_pkg::GAIN_W;

   logic [csps_pkg::OFFSET_W-1:0] mag;
   logic non_positive;
   logic out_of_range;
   logic beyond_second;
   logic signed [csps_pkg::MUL_W-1:0] off_short;
   logic signed [PROD_W-1:0] prod_i;
   logic signed [PROD_W-1:0] prod_p;
   csps_pkg::sum_type sum_i;
   csps_pkg::sum_type acc;
   csps_pkg::sum_type acc_clamped;
   csps_pkg::sum_type sum_p;
   csps_pkg::sum_type adj;
   logic signed [csps_pkg::RATIO_W-1:0] ratio;

   function automatic csps_pkg::sum_type trunc_scale(input csps_pkg::sum_type v);
      csps_pkg::sum_type bias;
      bias = v[csps_pkg::SUM_W-1] ? csps_pkg::sum_type'((64'd1 << F) - 64'd1) : '0;
      return (v + bias) >>> F;
   endfunction

   assign mag = offset_ns[csps_pkg::OFFSET_W-1] ? unsigned'(-offset_ns)
                                                : unsigned'(offset_ns);
   assign non_positive = offset_ns[csps_pkg::OFFSET_W-1] || (offset_ns == '0);
   assign out_of_range = mag >= {{(csps_pkg::OFFSET_W - csps_pkg::MAXOFF_W){1'b0}},
                                 cfg.offset_limit};
   assign beyond_second = mag >= csps_pkg::ONE_SECOND_NS;

   // In range the magnitude is below the 30-bit offset limit, so the low bits carry the offset.
   assign off_short = offset_ns[csps_pkg::MUL_W-1:0];
   assign prod_i = off_short * cfg.integ_gain;
   assign prod_p = off_short * cfg.prop_gain;

   always_comb begin
      sum_i = csps_pkg::sum_type'(prod_i) + (csps_pkg::sum_type'(state.integ) <<< F);
      acc = trunc_scale(sum_i);
      if (acc > csps_pkg::sum_type'(csps_pkg::ADJ_LIMIT)) begin
         acc_clamped = csps_pkg::sum_type'(csps_pkg::ADJ_LIMIT);
      end else if (acc < -csps_pkg::sum_type'(csps_pkg::ADJ_LIMIT)) begin
         acc_clamped = -csps_pkg::sum_type'(csps_pkg::ADJ_LIMIT);
      end else begin
         acc_clamped = acc;
      end
      sum_p = csps_pkg::sum_type'(prod_p) + (acc_clamped <<< F);
      adj = -trunc_scale(sum_p);
      if (adj > csps_pkg::sum_type'(64'sh7fffffff)) begin
         ratio = 32'sh7fffffff;
      end else if (adj < -csps_pkg::sum_type'(64'sh80000000)) begin
         ratio = -32'sh80000000;
      end else begin
         ratio = adj[csps_pkg::RATIO_W-1:0];
      end
   end

   always_comb begin
      state_next = state;
      result.action = csps_pkg::ACT_RATE;
      result.ratio_adjust = '0;
      result.step_ns = '0;
      if (state.phase == csps_pkg::PHASE_PENDING) begin
         if (non_positive) begin
            result.action = csps_pkg::ACT_STEP;
            result.step_ns = mag;
            state_next.integ = '0;
            state_next.phase = csps_pkg::PHASE_STEPPED;
         end else begin
            result.action = csps_pkg::ACT_REJECT;
         end
      end else if (out_of_range) begin
         result.action = csps_pkg::ACT_SKIP;
         if ((state.phase == csps_pkg::PHASE_STEPPED) || beyond_second) begin
            state_next.phase = csps_pkg::PHASE_PENDING;
         end
      end else begin
         result.ratio_adjust = ratio;
         state_next.integ = acc_clamped[csps_pkg::INTEG_W-1:0];
         state_next.phase = csps_pkg::PHASE_NORMAL;
      end
      result.reset_pending = (state_next.phase == csps_pkg::PHASE_PENDING);
   end

endmodule
`default_nettype wire

FILE: rtl/core/clock_sync_pi_servo_top.sv
// Top level of the PI clock servo: request and result registers, servo state, registers.
//
// The servo takes one offset request per clock cycle while the result is not stalled
// and presents its result from a result register: the request is captured in an
// input register, then the decision and PI arithmetic (two 31 by 32 bit multiplies
// in parallel, followed by the integrator add, clamp and output saturation) settle
// combinationally into the result register, where the integrator and phase are
// updated too, so the next request already sees them. The clock period is set by
// that multiply and add path. A stalled result holds; the request behind it waits
// in the input register and further requests are stalled until the result is taken.
// Gains and the offset limit are to be written through the register port (byte
// addresses 0, 4 and 8) while the servo is idle; the block does not enforce this.
`default_nettype none
module clock_sync_pi_servo_top (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic signed [csps_pkg::OFFSET_W-1:0] req_offset_ns,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [csps_pkg::ACTION_W-1:0] rsp_action,
   output logic signed [csps_pkg::RATIO_W-1:0] rsp_ratio_adjust,
   output logic [csps_pkg::OFFSET_W-1:0] rsp_step_ns,
   output logic rsp_reset_pending,
   input wire logic csr_psel,
   input wire logic csr_penable,
   input wire logic csr_pwrite,
   input wire logic [csps_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input wire logic [csps_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [csps_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);

   csps_pkg::cfg_type cfg;
   csps_pkg::state_type state_ff;
   csps_pkg::state_type state_in;
   csps_pkg::result_type result;
   csps_pkg::result_type out_ff;
   logic in_valid_ff;
   logic in_valid_in;
   logic signed [csps_pkg::OFFSET_W-1:0] in_offset_ff;
   logic signed [csps_pkg::OFFSET_W-1:0] in_offset_in;
   logic out_valid_ff;
   logic out_valid_in;
   csps_pkg::result_type out_in;
   logic out_free;
   logic move;
   logic take;

   csps_regs u_regs (
      .clock(clock),
      .reset(reset),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .cfg(cfg)
   );

   csps_pi u_pi (
      .offset_ns(in_offset_ff),
      .cfg(cfg),
      .state(state_ff),
      .state_next(state_in),
      .result(result)
   );

   assign out_free = !out_valid_ff || !rsp_stall;
   assign move = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign take = req_valid && !req_stall;

   assign in_valid_in = take || (in_valid_ff && !move);
   assign in_offset_in = take ? req_offset_ns : in_offset_ff;
   assign out_valid_in = move || (out_valid_ff && rsp_stall);
   assign out_in = move ? result : out_ff;

   assign rsp_valid = out_valid_ff;
   assign rsp_action = out_ff.action;
   assign rsp_ratio_adjust = out_ff.ratio_adjust;
   assign rsp_step_ns = out_ff.step_ns;
   assign rsp_reset_pending = out_ff.reset_pending;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff.phase <= csps_pkg::PHASE_PENDING;
         state_ff.integ <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (move) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_offset_ff <= in_offset_in;
      out_ff <= out_in;
   end

endmodule
`default_nettype wire
